// ===== rtl/bpa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared constants, payload structs and control structs of the bitmap page
// allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

   localparam int MAX_PAGES     = 4096;
   localparam int PAGE_BITS     = 12;
   localparam int ADDR_BITS     = 64;
   localparam int POOL_BITS     = 13;
   localparam int COUNT_BITS    = 12;
   localparam int ACTION_BITS   = 2;
   localparam int CSR_IDX_BITS  = 2;
   localparam int WORD_BITS     = 64;
   localparam int BIT_BITS      = $clog2(WORD_BITS);
   localparam int ROW_COUNT     = MAX_PAGES / WORD_BITS;
   localparam int ROW_BITS      = $clog2(ROW_COUNT);
   localparam int PAGE_IDX_BITS = $clog2(MAX_PAGES);

   localparam logic [ACTION_BITS-1:0] ACT_ALLOC = 2'd0;
   localparam logic [ACTION_BITS-1:0] ACT_FREE  = 2'd1;
   localparam logic [ACTION_BITS-1:0] ACT_XLAT  = 2'd2;

   localparam logic [CSR_IDX_BITS-1:0] CSR_PHYS_BASE = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_VIRT_BASE = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_POOL_SIZE = 2'd2;

   typedef struct packed {
      logic [ACTION_BITS-1:0] action;
      logic [ADDR_BITS-1:0]   target_address;
   } req_type;

   typedef struct packed {
      logic                  ok;
      logic [ADDR_BITS-1:0]  result_address;
      logic [COUNT_BITS-1:0] allocated_count;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic latch;
      logic prep;
      logic read;
      logic check;
      logic advance;
      logic finish;
      logic emit;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_alloc;
      logic is_free;
      logic free_bad;
      logic found;
      logic more_rows;
      logic out_free;
   } sts_type;

endpackage

// ===== rtl/bpa_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module bpa_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/bpa_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_ctrl
// Sequencer of the allocator: takes one request word, walks the map rows
// and hands the finished result to the output register.
// ----------------------------------------------------------------------------
module bpa_ctrl
   import bpa_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_PREP  = 6'b000010,
      ST_READ  = 6'b000100,
      ST_CHECK = 6'b001000,
      ST_ADDR  = 6'b010000,
      ST_DONE  = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = ST_PREP;
            end
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            if (sts.is_alloc || sts.is_free) begin
               state_in = ST_READ;
            end else begin
               state_in = ST_ADDR;
            end
         end
         ST_READ: begin
            // drop a misaligned or out of range free without touching the map
            if (sts.is_free && sts.free_bad) begin
               state_in = ST_ADDR;
            end else begin
               cmd.read = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
            if (sts.is_alloc && !sts.found && sts.more_rows) begin
               cmd.advance = 1'b1;
            end else begin
               state_in = ST_ADDR;
            end
         end
         ST_ADDR: begin
            cmd.finish = 1'b1;
            state_in   = ST_DONE;
         end
         ST_DONE: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

// ===== rtl/bpa_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_datapath
// Configuration registers, request latch, used-page map with row valid bits,
// first-fit search over one 64-page row per cycle, and the output register.
// ----------------------------------------------------------------------------
module bpa_datapath
   import bpa_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_wr_en,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [ADDR_BITS-1:0]    csr_wr_data,
   input  req_type                 req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output rsp_type                 rsp_data,
   input  cmd_type                 cmd,
   output sts_type                 sts
);

   logic [ADDR_BITS-1:0]     phys_base_ff;
   logic [ADDR_BITS-1:0]     virt_base_ff;
   logic [POOL_BITS-1:0]     pool_ff;

   logic [ACTION_BITS-1:0]   action_ff;
   logic [ADDR_BITS-1:0]     target_ff;
   logic [ADDR_BITS-1:0]     rel_ff;
   logic [ROW_BITS-1:0]      row_ff;
   logic [PAGE_IDX_BITS-1:0] page_ff;
   logic                     ok_ff;
   logic [COUNT_BITS-1:0]    used_total_ff;
   logic [ROW_COUNT-1:0]     row_valid_ff;
   logic                     rd_valid_ff;
   logic [ADDR_BITS-1:0]     res_addr_ff;
   logic                     res_ok_ff;
   logic                     rsp_valid_ff;
   rsp_type                  rsp_data_ff;

   logic                     is_alloc;
   logic                     is_free;
   logic                     is_xlat;
   logic [POOL_BITS-1:0]     live;
   logic [ROW_BITS-1:0]      free_row;
   logic [BIT_BITS-1:0]      free_bit;
   logic                     free_bad;
   logic [ROW_BITS-1:0]      rd_row;
   logic [ROW_BITS-1:0]      wr_row;
   logic                     ram_we;
   logic [WORD_BITS-1:0]     ram_wdata;
   logic                     ram_re;
   logic [WORD_BITS-1:0]     ram_q;
   logic [WORD_BITS-1:0]     word;
   logic [POOL_BITS-1:0]     row_base;
   logic [POOL_BITS-1:0]     row_left;
   logic [WORD_BITS-1:0]     range_mask;
   logic [WORD_BITS-1:0]     avail;
   logic                     found;
   logic [BIT_BITS-1:0]      pick_bit;
   logic                     more_rows;
   logic                     free_hit;

   assign is_alloc = (action_ff == ACT_ALLOC);
   assign is_free  = (action_ff == ACT_FREE);
   assign is_xlat  = (action_ff == ACT_XLAT);

   assign live = (pool_ff > POOL_BITS'(MAX_PAGES)) ? POOL_BITS'(MAX_PAGES) : pool_ff;

   // free: page index and its place in the map
   assign free_row = rel_ff[PAGE_BITS+BIT_BITS +: ROW_BITS];
   assign free_bit = rel_ff[PAGE_BITS +: BIT_BITS];
   assign free_bad = (rel_ff[PAGE_BITS-1:0] != '0)
                  || (rel_ff[ADDR_BITS-1:PAGE_BITS+PAGE_IDX_BITS] != '0)
                  || ({1'b0, rel_ff[PAGE_BITS +: PAGE_IDX_BITS]} >= live);

   // rows never written read as all free
   assign word = rd_valid_ff ? ram_q : '0;

   // allocate: mask off page 0 and pages at or beyond the pool end
   assign row_base = POOL_BITS'({row_ff, BIT_BITS'(0)});
   assign row_left = live - row_base;

   always_comb begin
      if (live <= row_base) begin
         range_mask = '0;
      end else if (row_left >= POOL_BITS'(WORD_BITS)) begin
         range_mask = '1;
      end else begin
         range_mask = ~({WORD_BITS{1'b1}} << row_left[BIT_BITS-1:0]);
      end
      if (row_ff == '0) begin
         range_mask[0] = 1'b0;
      end
   end

   assign avail = ~word & range_mask;
   assign found = |avail;

   always_comb begin
      pick_bit = '0;
      for (int b = WORD_BITS - 1; b >= 0; b--) begin
         if (avail[b]) begin
            pick_bit = BIT_BITS'(b);
         end
      end
   end

   assign more_rows = (row_base + POOL_BITS'(WORD_BITS)) < live;
   assign free_hit  = word[free_bit];

   assign rd_row = is_free ? free_row
                 : (cmd.advance ? ROW_BITS'(row_ff + 1'b1) : row_ff);
   assign wr_row = is_free ? free_row : row_ff;
   assign ram_re = cmd.read || cmd.advance;
   assign ram_we = cmd.check && ((is_alloc && found) || (is_free && free_hit));
   assign ram_wdata = is_free ? (word & ~(WORD_BITS'(1) << free_bit))
                              : (word | (WORD_BITS'(1) << pick_bit));

   bpa_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (ROW_COUNT)
   ) u_map (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wr_row),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (rd_row),
      .rd_data (ram_q)
   );

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         phys_base_ff <= '0;
         virt_base_ff <= '0;
         pool_ff      <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_PHYS_BASE: phys_base_ff <= csr_wr_data;
            CSR_VIRT_BASE: virt_base_ff <= csr_wr_data;
            CSR_POOL_SIZE: pool_ff      <= csr_wr_data[POOL_BITS-1:0];
            default: ;
         endcase
      end
   end

   // control state of the map
   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff  <= '0;
         used_total_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (ram_we) begin
            row_valid_ff[wr_row] <= 1'b1;
            if (is_free) begin
               used_total_ff <= used_total_ff - 1'b1;
            end else begin
               used_total_ff <= used_total_ff + 1'b1;
            end
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         action_ff <= req_data.action;
         target_ff <= req_data.target_address;
      end
      if (cmd.prep) begin
         rel_ff <= target_ff - phys_base_ff;
         row_ff <= '0;
         ok_ff  <= 1'b0;
      end
      if (ram_re) begin
         rd_valid_ff <= row_valid_ff[rd_row];
      end
      if (cmd.advance) begin
         row_ff <= ROW_BITS'(row_ff + 1'b1);
      end
      if (ram_we) begin
         ok_ff   <= 1'b1;
         page_ff <= {row_ff, pick_bit};
      end
      if (cmd.finish) begin
         if (is_alloc && ok_ff) begin
            res_addr_ff <= phys_base_ff + (ADDR_BITS'(page_ff) << PAGE_BITS);
         end else if (is_xlat) begin
            res_addr_ff <= rel_ff + virt_base_ff;
         end else begin
            res_addr_ff <= '0;
         end
         res_ok_ff <= is_xlat || ok_ff;
      end
      if (cmd.emit) begin
         rsp_data_ff.ok              <= res_ok_ff;
         rsp_data_ff.result_address  <= res_addr_ff;
         rsp_data_ff.allocated_count <= used_total_ff;
      end
   end

   assign sts.is_alloc  = is_alloc;
   assign sts.is_free   = is_free;
   assign sts.free_bad  = free_bad;
   assign sts.found     = found;
   assign sts.more_rows = more_rows;
   assign sts.out_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/bitmap_page_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_page_allocator
// First-fit page frame allocator with one used bit per page, plus free and
// physical to virtual translation.
// ----------------------------------------------------------------------------
//  port group  direction  handshake             word
//  req_*       in         req_valid / req_stall  req_type (action, address)
//  rsp_*       out        rsp_valid / rsp_stall  rsp_type (ok, address, count)
//  csr_*       in         csr_wr_en              index + 64-bit data
//
//  One request at a time. Allocate scans the 64-page map rows in order, up to
//  64 rows for 4096 pages: the map RAM delivers one row per cycle. Free reads
//  and checks only the row of its page and skips the map when the address fails
//  the alignment or range check; translate does not touch the map.
//  Reset clears the row valid bits at once, so no clearing pass runs. A
//  finished result waits in the output register while rsp_stall is high;
//  the next request can be accepted meanwhile.
// ----------------------------------------------------------------------------
module bitmap_page_allocator
   import bpa_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_wr_en,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [ADDR_BITS-1:0]    csr_wr_data,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  req_type                 req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output rsp_type                 rsp_data
);

   cmd_type cmd;
   sts_type sts;

   bpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   bpa_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .cmd         (cmd),
      .sts         (sts)
   );

   // a taken request blocks the input until its result is handed over
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while another is in flight");

   // the output register is only reloaded when its word has left
   assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid || !rsp_stall))
      else $error("result overwrote a pending word");

   // the map is only touched for a free that passed the range checks
   assert property (@(posedge clock) disable iff (reset)
      (cmd.check && sts.is_free) |-> !sts.free_bad)
      else $error("map read for an invalid free");

   // the scan moves on only when the current row has no free page
   assert property (@(posedge clock) disable iff (reset)
      cmd.advance |-> (!sts.found && sts.more_rows))
      else $error("row scan advanced past a free page");

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench of the bitmap page allocator. A short table of requests and
// register writes covers the corners: empty pool, full pool, address wrap,
// bad frees, clamped and shrunk pools. Random phases follow, each under its
// own register setting. Every response word is checked against the table's
// fixed result or a model of the page map that runs alongside the block.
// ----------------------------------------------------------------------------
module tb;
   import bpa_pkg::*;

   localparam logic [ACTION_BITS-1:0] ACT_NONE = 2'd3;
   localparam int PHASES       = 32;
   localparam int PHASE_WORDS  = 48;
   localparam int LONG_HOLD    = 400;
   localparam int IDLE_LIMIT   = 3000;
   localparam int DRAIN_CYCLES = 100;
   localparam int MAX_REPORTS  = 10;
   localparam logic [ADDR_BITS-1:0] PAGE_BYTES = 64'd1 << PAGE_BITS;

   typedef struct {
      bit                      is_write;
      logic [CSR_IDX_BITS-1:0] index;
      logic [ADDR_BITS-1:0]    value;
      req_type                 word;
      bit                      typed;
      rsp_type                 result;
   } plan_row_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    csr_wr_en = 1'b0;
   logic [CSR_IDX_BITS-1:0] csr_index = '0;
   logic [ADDR_BITS-1:0]    csr_wr_data = '0;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   req_type                 req_data = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   rsp_type                 rsp_data;

   // model of the pool
   logic [ADDR_BITS-1:0] phys_base = '0;
   logic [ADDR_BITS-1:0] virt_base = '0;
   logic [POOL_BITS-1:0] pool_pages = '0;
   bit                   page_used [MAX_PAGES];
   int unsigned          used_pages = 0;

   rsp_type      pending_results [$];
   plan_row_type plan [$];
   int unsigned  mismatches = 0;
   int unsigned  idle_cycles = 0;
   bit           no_idle = 1'b0;
   bit           hold_request = 1'b0;

   always #5 clock = ~clock;

   bitmap_page_allocator i_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

   function automatic int unsigned live_pages();
      return (pool_pages > MAX_PAGES) ? MAX_PAGES : int'(pool_pages);
   endfunction

   function automatic rsp_type predict_page_op(input req_type w);
      rsp_type              r;
      logic [ADDR_BITS-1:0] offset;
      logic [ADDR_BITS-1:0] page;
      int unsigned          n;
      r = '0;
      n = live_pages();
      case (w.action)
         ACT_ALLOC: begin
            for (int i = 1; i < n; i++) begin
               if (!page_used[i]) begin
                  page_used[i] = 1'b1;
                  used_pages++;
                  r.ok = 1'b1;
                  r.result_address = phys_base + (ADDR_BITS'(i) << PAGE_BITS);
                  break;
               end
            end
         end
         ACT_FREE: begin
            offset = w.target_address - phys_base;
            page = offset >> PAGE_BITS;
            if (offset[PAGE_BITS-1:0] == '0 && page < n) begin
               if (page_used[page[PAGE_IDX_BITS-1:0]]) begin
                  page_used[page[PAGE_IDX_BITS-1:0]] = 1'b0;
                  used_pages--;
                  r.ok = 1'b1;
               end
            end
         end
         ACT_XLAT: begin
            r.ok = 1'b1;
            r.result_address = w.target_address - phys_base + virt_base;
         end
         default: ;
      endcase
      r.allocated_count = COUNT_BITS'(used_pages);
      return r;
   endfunction

   function automatic plan_row_type req_row(input logic [ACTION_BITS-1:0] a,
                                            input logic [ADDR_BITS-1:0] t);
      plan_row_type p;
      p = '{default: '0};
      p.word.action = a;
      p.word.target_address = t;
      return p;
   endfunction

   function automatic plan_row_type fixed_row(input logic [ACTION_BITS-1:0] a,
                                              input logic [ADDR_BITS-1:0] t,
                                              input logic ok,
                                              input logic [ADDR_BITS-1:0] ra,
                                              input int unsigned cnt);
      plan_row_type p;
      p = req_row(a, t);
      p.typed = 1'b1;
      p.result.ok = ok;
      p.result.result_address = ra;
      p.result.allocated_count = COUNT_BITS'(cnt);
      return p;
   endfunction

   function automatic plan_row_type reg_row(input logic [CSR_IDX_BITS-1:0] idx,
                                            input logic [ADDR_BITS-1:0] v);
      plan_row_type p;
      p = '{default: '0};
      p.is_write = 1'b1;
      p.index = idx;
      p.value = v;
      return p;
   endfunction

   function automatic void note_mismatch(input string field, input logic [ADDR_BITS-1:0] want,
                                         input logic [ADDR_BITS-1:0] got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("%0t: %s mismatch: expected %h, got %h", $realtime, field, want, got);
   endfunction

   // drop valid, wait for every outstanding response, then pause
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_BITS-1:0] idx, input logic [ADDR_BITS-1:0] v);
      settle();
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_PHYS_BASE: phys_base = v;
         CSR_VIRT_BASE: virt_base = v;
         CSR_POOL_SIZE: pool_pages = v[POOL_BITS-1:0];
         default: ;
      endcase
   endtask

   task automatic send_word(input req_type w, input bit typed, input rsp_type fixed);
      int unsigned gap;
      rsp_type     predicted;
      gap = no_idle ? 0 : $urandom_range(15, 0);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (!(req_valid && !req_stall));
      predicted = predict_page_op(w);
      pending_results.push_back(typed ? fixed : predicted);
   endtask

   // response checker
   always @(posedge clock) begin : check_responses
      rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            note_mismatch("unexpected response, address", '0, rsp_data.result_address);
         end else begin
            e = pending_results.pop_front();
            if (rsp_data.ok !== e.ok)
               note_mismatch("ok", ADDR_BITS'(e.ok), ADDR_BITS'(rsp_data.ok));
            if (rsp_data.result_address !== e.result_address)
               note_mismatch("result_address", e.result_address, rsp_data.result_address);
            if (rsp_data.allocated_count !== e.allocated_count)
               note_mismatch("allocated_count", ADDR_BITS'(e.allocated_count),
                             ADDR_BITS'(rsp_data.allocated_count));
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_wr_en) begin
         idle_cycles <= 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
         $display("Mismatches found");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // response side: random stall before each word, one long hold on request
   initial begin : rsp_side
      int unsigned hold;
      wait (!reset);
      forever begin
         hold = no_idle ? 0 : $urandom_range(15, 0);
         if (hold_request) begin
            hold = LONG_HOLD;
            hold_request = 1'b0;
         end
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   initial begin : stimulus
      req_type              w;
      rsp_type              none;
      logic [ADDR_BITS-1:0] v;
      int unsigned          n, pick, alloc_pct, r, sel;

      none = '0;
      // empty pool after reset
      plan.push_back(fixed_row(ACT_ALLOC, '0, 1'b0, '0, 0));
      plan.push_back(fixed_row(ACT_FREE, '0, 1'b0, '0, 0));
      plan.push_back(fixed_row(ACT_XLAT, '1, 1'b1, '1, 0));
      plan.push_back(fixed_row(ACT_NONE, '1, 1'b0, '0, 0));
      // three pages, base near the top so page 2 wraps to zero
      plan.push_back(reg_row(CSR_PHYS_BASE, 64'hFFFF_FFFF_FFFF_E000));
      plan.push_back(reg_row(CSR_VIRT_BASE, 64'h8000_0000_0000_0000));
      plan.push_back(reg_row(CSR_POOL_SIZE, 64'hABCD_0000_0000_0003));
      plan.push_back(fixed_row(ACT_ALLOC, '0, 1'b1, 64'hFFFF_FFFF_FFFF_F000, 1));
      plan.push_back(fixed_row(ACT_ALLOC, '1, 1'b1, 64'h0, 2));
      plan.push_back(fixed_row(ACT_ALLOC, '0, 1'b0, '0, 2));
      plan.push_back(fixed_row(ACT_FREE, 64'hFFFF_FFFF_FFFF_F001, 1'b0, '0, 2));
      plan.push_back(fixed_row(ACT_FREE, 64'hFFFF_FFFF_FFFF_E000, 1'b0, '0, 2));
      plan.push_back(fixed_row(ACT_FREE, 64'h1000, 1'b0, '0, 2));
      plan.push_back(fixed_row(ACT_FREE, 64'hFFFF_FFFF_FFFF_D000, 1'b0, '0, 2));
      plan.push_back(fixed_row(ACT_FREE, 64'h0, 1'b1, '0, 1));
      plan.push_back(fixed_row(ACT_FREE, 64'h0, 1'b0, '0, 1));
      plan.push_back(fixed_row(ACT_XLAT, 64'hFFFF_FFFF_FFFF_E000, 1'b1,
                               64'h8000_0000_0000_0000, 1));
      plan.push_back(fixed_row(ACT_XLAT, 64'h0, 1'b1, 64'h8000_0000_0000_2000, 1));
      // oversized pool clamps, then shrink below the used pages
      plan.push_back(reg_row(CSR_POOL_SIZE, 64'd8191));
      plan.push_back(req_row(ACT_ALLOC, '0));
      plan.push_back(req_row(ACT_ALLOC, '0));
      plan.push_back(reg_row(CSR_POOL_SIZE, 64'd2));
      plan.push_back(req_row(ACT_FREE, 64'h1000));
      plan.push_back(req_row(ACT_ALLOC, '0));
      plan.push_back(reg_row(CSR_POOL_SIZE, 64'd1));
      plan.push_back(req_row(ACT_ALLOC, '0));
      plan.push_back(req_row(ACT_FREE, 64'hFFFF_FFFF_FFFF_F000));
      plan.push_back(reg_row(CSR_POOL_SIZE, MAX_PAGES));
      plan.push_back(req_row(ACT_FREE, 64'hFFFF_FFFF_FFFF_F000));
      plan.push_back(req_row(ACT_FREE, 64'h1000));
      plan.push_back(req_row(ACT_FREE, 64'h0));

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[k]) begin
         if (plan[k].is_write)
            write_reg(plan[k].index, plan[k].value);
         else
            send_word(plan[k].word, plan[k].typed, plan[k].result);
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         no_idle = (ph % 5 == 3) || (ph == 6);
         case ($urandom_range(9, 0))
            0:       v = '0;
            1:       v = 64'd1;
            2:       v = MAX_PAGES;
            3:       v = $urandom_range(8191, MAX_PAGES + 1);
            4:       v = $urandom_range(300, 65);
            default: v = $urandom_range(40, 2);
         endcase
         if ($urandom_range(3, 0) == 0)
            v[ADDR_BITS-1:POOL_BITS] = (ADDR_BITS-POOL_BITS)'({$urandom, $urandom});
         write_reg(CSR_POOL_SIZE, v);
         if ($urandom_range(1, 0) == 1) begin
            case ($urandom_range(3, 0))
               0:       v = '0;
               1:       v = -(PAGE_BYTES * $urandom_range(8, 1));
               2:       v = {$urandom, $urandom} & ~(PAGE_BYTES - 1);
               default: v = {$urandom, $urandom};
            endcase
            write_reg(CSR_PHYS_BASE, v);
         end
         if ($urandom_range(2, 0) == 0)
            write_reg(CSR_VIRT_BASE, ($urandom_range(3, 0) == 0) ? '1 : {$urandom, $urandom});
         // let the block fill up behind a held response
         if (ph == 6)
            hold_request = 1'b1;
         alloc_pct = $urandom_range(70, 20);

         for (int k = 0; k < PHASE_WORDS; k++) begin
            n = live_pages();
            w.target_address = {$urandom, $urandom};
            r = $urandom_range(99, 0);
            sel = $urandom_range(9, 0);
            if (r < alloc_pct) begin
               w.action = ACT_ALLOC;
            end else if (sel <= 5) begin
               w.action = ACT_FREE;
               // find a used page from a random start
               pick = (n > 1) ? $urandom_range(n - 1, 1) : 0;
               for (int s = 0; s < n && !page_used[pick]; s++)
                  pick = (pick + 1 < n) ? pick + 1 : 0;
               case ($urandom_range(9, 0))
                  0: w.target_address = phys_base + (ADDR_BITS'(pick) << PAGE_BITS)
                                        + $urandom_range(32'(PAGE_BYTES - 1), 1);
                  1: ;
                  2: w.target_address = phys_base
                                        + (ADDR_BITS'($urandom_range(n + 2, 0)) << PAGE_BITS);
                  default: w.target_address = phys_base + (ADDR_BITS'(pick) << PAGE_BITS);
               endcase
            end else if (sel <= 8) begin
               w.action = ACT_XLAT;
               if ($urandom_range(1, 0) == 1)
                  w.target_address = phys_base + $urandom_range(1 << 20, 0);
            end else begin
               w.action = ACT_NONE;
            end
            send_word(w, 1'b0, none);
         end
      end

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
